// File: src/debounced_event_counter_display_assert.svh
// assertion macros for the debounced event counter display
// expects signals named clk and rst_n in the module that uses them
`ifndef DEBOUNCED_EVENT_COUNTER_DISPLAY_ASSERT_SVH
`define DEBOUNCED_EVENT_COUNTER_DISPLAY_ASSERT_SVH

// same-cycle implication
`define DEC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dec assertion failed");

// next-cycle implication
`define DEC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dec assertion failed");

`endif

// File: src/dec_pkg.sv
// shared constants, types and segment decode for the event counter display
// no dependencies
`timescale 1ns / 1ps
package dec_pkg;

  localparam int DIGITS      = 8;
  localparam int SEL_W       = 8;
  localparam int POS_W       = 4;
  localparam int DIGIT_IDX_W = 3;
  localparam int BCD_DIGITS  = 8;
  localparam int COUNT_W     = 27;
  localparam int FILT_W      = 8;
  localparam int CFG_W       = 8;

  localparam logic [COUNT_W-1:0] COUNT_WRAP_ABOVE = 27'd99999998;
  localparam logic [COUNT_W-1:0] COUNT_MAX        = 27'd99999999;

  localparam logic [FILT_W-1:0] DEBOUNCE_LIMIT_RST = 8'd10;
  localparam logic [FILT_W-1:0] RELEASE_LEVEL_RST  = 8'd3;

  localparam logic [7:0] DASH_CODE  = 8'b10111111;
  localparam logic [7:0] BLANK_CODE = 8'b11111111;

  typedef enum logic [0:0] {
    CFG_DEBOUNCE_LIMIT = 1'b0,
    CFG_RELEASE_LEVEL  = 1'b1
  } cfg_idx_t;

  typedef logic [BCD_DIGITS-1:0][3:0] bcd_t;

  // control for one counter step
  typedef struct packed {
    logic step;
    logic zero;
    logic inc;
  } cnt_ctrl_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count_value;
    logic               counting_shown;
    logic [SEL_W-1:0]   digit_select;
    logic [7:0]         segment_code;
  } result_t;

  // active-low seven-segment pattern for a decimal digit
  function automatic logic [7:0] seg_decode(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0: code = 8'b11000000;
      4'd1: code = 8'b11111001;
      4'd2: code = 8'b10100100;
      4'd3: code = 8'b10110000;
      4'd4: code = 8'b10011001;
      4'd5: code = 8'b10010010;
      4'd6: code = 8'b10000010;
      4'd7: code = 8'b11111000;
      4'd8: code = 8'b10000000;
      4'd9: code = 8'b10010000;
      default: code = BLANK_CODE;
    endcase
    return code;
  endfunction

endpackage

// File: src/dec_in_if.sv
// input sample channel: valid/ready with the three sampled levels
// uses no package
`timescale 1ns / 1ps
interface dec_in_if;
  logic valid;
  logic ready;
  logic count_level;
  logic clear_level;
  logic scan_tick;

  modport source (output valid, output count_level, output clear_level, output scan_tick,
                  input ready);
  modport sink (input valid, input count_level, input clear_level, input scan_tick,
                output ready);
endinterface

// File: src/dec_out_if.sv
// result channel: valid/ready with count and display outputs
// depends on dec_pkg for widths
`timescale 1ns / 1ps
interface dec_out_if;
  logic                          valid;
  logic                          ready;
  logic [dec_pkg::COUNT_W-1:0]   count_value;
  logic                          counting_shown;
  logic [dec_pkg::SEL_W-1:0]     digit_select;
  logic [7:0]                    segment_code;

  modport source (output valid, output count_value, output counting_shown,
                  output digit_select, output segment_code, input ready);
  modport sink (input valid, input count_value, input counting_shown,
                input digit_select, input segment_code, output ready);
endinterface

// File: src/dec_debounce.sv
// counting debouncer with hysteresis, one sample per enabled cycle
// depends on dec_pkg
`timescale 1ns / 1ps
module dec_debounce (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        level,
  input  logic [dec_pkg::FILT_W-1:0]  limit,
  input  logic [dec_pkg::FILT_W-1:0]  release_lvl,
  output logic                        fire
);

  logic [dec_pkg::FILT_W-1:0] filter_r, filter_nxt;
  logic                       latched_r, latched_nxt;

  always_comb begin
    filter_nxt  = filter_r;
    latched_nxt = latched_r;
    fire        = 1'b0;
    if (!level) begin
      if (filter_r != '0) begin
        filter_nxt = filter_r - 1'b1;
        if (filter_nxt < release_lvl) begin
          latched_nxt = 1'b0;
        end
      end
    end else if (!latched_r) begin
      if (filter_r < limit) begin
        filter_nxt = filter_r + 1'b1;
      end
      if (filter_nxt >= limit) begin
        latched_nxt = 1'b1;
        fire        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_r  <= '0;
      latched_r <= 1'b0;
    end else if (en) begin
      filter_r  <= filter_nxt;
      latched_r <= latched_nxt;
    end
  end

endmodule

// File: src/dec_counter.sv
// event count kept both in binary and in packed bcd for the display
// depends on dec_pkg
`timescale 1ns / 1ps
module dec_counter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dec_pkg::cnt_ctrl_t           ctrl,
  output logic [dec_pkg::COUNT_W-1:0]  count_nxt,
  output dec_pkg::bcd_t                bcd_nxt
);

  logic [dec_pkg::COUNT_W-1:0] count_r;
  dec_pkg::bcd_t               bcd_r;
  logic [dec_pkg::COUNT_W-1:0] count_base;
  dec_pkg::bcd_t               bcd_base;
  logic                        zero_base;
  logic                        carry;

  always_comb begin
    // all nines from the previous step wraps before anything else
    zero_base  = (count_r > dec_pkg::COUNT_WRAP_ABOVE) || ctrl.zero;
    count_base = zero_base ? '0 : count_r;
    bcd_base   = zero_base ? '0 : bcd_r;
    count_nxt  = count_base + dec_pkg::COUNT_W'(ctrl.inc);
    bcd_nxt    = bcd_base;
    carry      = ctrl.inc;
    for (int i = 0; i < dec_pkg::BCD_DIGITS; i++) begin
      if (carry) begin
        if (bcd_base[i] == 4'd9) begin
          bcd_nxt[i] = 4'd0;
        end else begin
          bcd_nxt[i] = bcd_base[i] + 4'd1;
          carry      = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      bcd_r   <= '0;
    end else if (ctrl.step) begin
      count_r <= count_nxt;
      bcd_r   <= bcd_nxt;
    end
  end

endmodule

// File: src/dec_scan.sv
// display multiplexer: scan position, one-hot select and segment pattern
// depends on dec_pkg
`timescale 1ns / 1ps
module dec_scan (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        tick,
  input  dec_pkg::bcd_t               bcd_nxt,
  input  logic                        show_nxt,
  output logic [dec_pkg::SEL_W-1:0]   digit_select,
  output logic [7:0]                  segment_code
);

  logic [dec_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic [dec_pkg::POS_W-1:0]       pos_m1;
  logic [dec_pkg::DIGIT_IDX_W-1:0] k;

  always_comb begin
    pos_nxt = pos_r;
    if (tick) begin
      if (pos_r >= dec_pkg::POS_W'(dec_pkg::DIGITS)) begin
        pos_nxt = dec_pkg::POS_W'(1);
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
    pos_m1       = pos_nxt - 1'b1;
    k            = pos_m1[dec_pkg::DIGIT_IDX_W-1:0];
    digit_select = '0;
    segment_code = dec_pkg::BLANK_CODE;
    // position zero means no digit has been scanned yet
    if (pos_nxt != '0) begin
      digit_select    = '0;
      digit_select[k] = 1'b1;
      segment_code    = show_nxt ? dec_pkg::seg_decode(bcd_nxt[k]) : dec_pkg::DASH_CODE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (en) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// File: src/debounced_event_counter_display.sv
// Debounced eight-digit event counter with a multiplexed seven-segment output.
// Input channel in_if carries one sample tick: count level, clear level and a
// scan flag. Each transfer yields exactly one result on out_if: the binary
// count, whether the count is shown, a one-hot digit select and the active-low
// segment pattern of that digit (dashes while paused, blank before the first
// scan tick).
// cfg_we/cfg_index/cfg_wdata write the debounce limit (index 0) and release
// level (index 1); write them only while no sample is in flight.
// A sample is first captured in the input register and is then processed into
// the result register when it advances; its result is valid from then on.
// Throughput is one sample per cycle while the receiver keeps ready high, set
// by the single input register feeding the single result register.
// Reset (synchronous, rst_n low) zeroes the count and filters, resumes the
// display and deselects all digits; limit returns to 10, release level to 3.
// If the receiver holds ready low, the result register holds and one more
// sample is kept in the input register before in_if.ready drops.
// depends on dec_pkg, dec_in_if, dec_out_if, dec_debounce, dec_counter, dec_scan
`timescale 1ns / 1ps
`include "debounced_event_counter_display_assert.svh"
module debounced_event_counter_display (
  input  logic                        clk,
  input  logic                        rst_n,
  dec_in_if.sink                      in_if,
  dec_out_if.source                   out_if,
  input  logic                        cfg_we,
  input  dec_pkg::cfg_idx_t           cfg_index,
  input  logic [dec_pkg::CFG_W-1:0]   cfg_wdata
);

  logic [dec_pkg::FILT_W-1:0] limit_r;
  logic [dec_pkg::FILT_W-1:0] release_r;

  logic s1_valid_r;
  logic count_lvl_r, clear_lvl_r, scan_r;
  logic advance;

  logic paused_r, paused_nxt;
  logic clear_fire, count_fire;

  dec_pkg::cnt_ctrl_t          cnt_ctrl;
  logic [dec_pkg::COUNT_W-1:0] count_nxt;
  dec_pkg::bcd_t               bcd_nxt;
  logic [dec_pkg::SEL_W-1:0]   sel_nxt;
  logic [7:0]                  seg_nxt;

  logic             out_valid_r;
  dec_pkg::result_t res_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= dec_pkg::DEBOUNCE_LIMIT_RST;
      release_r <= dec_pkg::RELEASE_LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dec_pkg::CFG_DEBOUNCE_LIMIT: limit_r   <= cfg_wdata;
        dec_pkg::CFG_RELEASE_LEVEL:  release_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign advance     = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      count_lvl_r <= in_if.count_level;
      clear_lvl_r <= in_if.clear_level;
      scan_r      <= in_if.scan_tick;
    end
  end

  dec_debounce u_clear_db (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (advance),
    .level       (clear_lvl_r),
    .limit       (limit_r),
    .release_lvl (release_r),
    .fire        (clear_fire)
  );

  dec_debounce u_count_db (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (advance),
    .level       (count_lvl_r),
    .limit       (limit_r),
    .release_lvl (release_r),
    .fire        (count_fire)
  );

  // clear toggles pause; leaving pause zeroes the count
  always_comb begin
    paused_nxt    = clear_fire ? !paused_r : paused_r;
    cnt_ctrl.step = advance;
    cnt_ctrl.zero = clear_fire && paused_r;
    cnt_ctrl.inc  = count_fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paused_r <= 1'b0;
    end else if (advance) begin
      paused_r <= paused_nxt;
    end
  end

  dec_counter u_counter (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (cnt_ctrl),
    .count_nxt (count_nxt),
    .bcd_nxt   (bcd_nxt)
  );

  dec_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (advance),
    .tick         (scan_r),
    .bcd_nxt      (bcd_nxt),
    .show_nxt     (!paused_nxt),
    .digit_select (sel_nxt),
    .segment_code (seg_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r.count_value    <= count_nxt;
      res_r.counting_shown <= !paused_nxt;
      res_r.digit_select   <= sel_nxt;
      res_r.segment_code   <= seg_nxt;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.count_value    = res_r.count_value;
  assign out_if.counting_shown = res_r.counting_shown;
  assign out_if.digit_select   = res_r.digit_select;
  assign out_if.segment_code   = res_r.segment_code;

  `DEC_ASSERT_NXT(a_advance_gives_result, advance, out_valid_r)
  `DEC_ASSERT_IMP(a_count_in_range, out_valid_r, res_r.count_value <= dec_pkg::COUNT_MAX)
  `DEC_ASSERT_IMP(a_blank_unselected, out_valid_r && res_r.digit_select == '0,
                  res_r.segment_code == dec_pkg::BLANK_CODE)
  `DEC_ASSERT_IMP(a_dash_when_paused,
                  out_valid_r && !res_r.counting_shown && res_r.digit_select != '0,
                  res_r.segment_code == dec_pkg::DASH_CODE)

endmodule
